### sv/servo_position_remap_macros.svh
// Assertion macros for the servo position remap block.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef SERVO_POSITION_REMAP_MACROS_SVH
`define SERVO_POSITION_REMAP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define SPR_ASSERT_IMP(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("servo_position_remap: check failed");
// Next-cycle implication check.
`define SPR_ASSERT_NXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("servo_position_remap: check failed");
`else
`define SPR_ASSERT_IMP(name, cond, expr)
`define SPR_ASSERT_NXT(name, cond, expr)
`endif
`endif

### sv/spr_pkg.sv
// Shared types and constants for the servo position remap block.
// No dependencies; used by the channel interfaces and the top level.
package spr_pkg;

  localparam int CFG_INDEX_BITS = 3;

  // Configuration register indexes, in register-map order.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEADER_LOW      = 3'd0,
    CFG_LEADER_HIGH     = 3'd1,
    CFG_LEADER_CENTER   = 3'd2,
    CFG_FOLLOWER_LOW    = 3'd3,
    CFG_FOLLOWER_HIGH   = 3'd4,
    CFG_FOLLOWER_CENTER = 3'd5,
    CFG_REVERSE         = 3'd6,
    CFG_TRIM            = 3'd7
  } cfg_index_t;

endpackage

### sv/spr_interfaces.sv
// Valid/ready channel interfaces for the servo position remap block.
// Depends on spr_pkg for the configuration register index type.

// Leader position input channel.
interface spr_leader_if #(
  parameter int POSITION_BITS = 12
) ();
  logic                     valid;
  logic                     ready;
  logic [POSITION_BITS-1:0] leader_position;

  modport source (output valid, output leader_position, input ready);
  modport sink (input valid, input leader_position, output ready);
endinterface

// Follower target output channel.
interface spr_follower_if #(
  parameter int POSITION_BITS = 12
) ();
  logic                     valid;
  logic                     ready;
  logic [POSITION_BITS-1:0] mapped_position;

  modport source (output valid, output mapped_position, input ready);
  modport sink (input valid, input mapped_position, output ready);
endinterface

// Configuration write channel.
interface spr_cfg_if import spr_pkg::*; #(
  parameter int DATA_BITS = 13
) ();
  logic                 valid;
  logic                 ready;
  cfg_index_t           index;
  logic [DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/servo_position_remap.sv
// Top level of the servo position remap block: config registers and the remap pipeline.
// Depends on spr_pkg, spr_interfaces, spr_divider and servo_position_remap_macros.svh.
//
// Maps a leader joint position onto the follower range about the two centers, with
// separate up and down spans, optional reversal, a signed trim, rounding half away
// from zero and a final clamp into the follower limits. One word is accepted every
// cycle while the output does not stall; each word passes through the three front
// stages (span, clamp, multiply), one divider stage per quotient bit, and the three
// back stages (round, add, clamp).
// Every stage has its own valid bit, so bubbles close up under output stalls.
// Configuration words are taken every cycle and must only be written while the
// pipeline is empty.
`include "servo_position_remap_macros.svh"

module servo_position_remap import spr_pkg::*; #(
  parameter int POSITION_BITS = 12
) (
  input  logic           clk,
  input  logic           rst,
  spr_cfg_if.sink        cfg,
  spr_leader_if.sink     leader,
  spr_follower_if.source follower
);

  localparam int P         = POSITION_BITS;
  localparam int PROD_BITS = 2 * POSITION_BITS;
  localparam logic [P-1:0] POS_ONE    = {{(P-1){1'b0}}, 1'b1};
  localparam logic [P-1:0] POS_MAX    = {P{1'b1}};
  localparam logic [P-1:0] POS_CENTER = {1'b1, {(P-1){1'b0}}};

  // Configuration registers.
  logic [P-1:0]        leader_low_limit;
  logic [P-1:0]        leader_high_limit;
  logic [P-1:0]        leader_center;
  logic [P-1:0]        follower_low_limit;
  logic [P-1:0]        follower_high_limit;
  logic [P-1:0]        follower_center;
  logic                reverse_direction;
  logic signed [P:0]   offset_trim;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_low_limit    <= '0;
      leader_high_limit   <= POS_MAX;
      leader_center       <= POS_CENTER;
      follower_low_limit  <= '0;
      follower_high_limit <= POS_MAX;
      follower_center     <= POS_CENTER;
      reverse_direction   <= 1'b0;
      offset_trim         <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_LEADER_LOW:      leader_low_limit    <= cfg.data[P-1:0];
        CFG_LEADER_HIGH:     leader_high_limit   <= cfg.data[P-1:0];
        CFG_LEADER_CENTER:   leader_center       <= cfg.data[P-1:0];
        CFG_FOLLOWER_LOW:    follower_low_limit  <= cfg.data[P-1:0];
        CFG_FOLLOWER_HIGH:   follower_high_limit <= cfg.data[P-1:0];
        CFG_FOLLOWER_CENTER: follower_center     <= cfg.data[P-1:0];
        CFG_REVERSE:         reverse_direction   <= cfg.data[0];
        CFG_TRIM:            offset_trim         <= signed'(cfg.data[P:0]);
        default: ;
      endcase
    end
  end

  // Absolute distance between two positions, never less than one.
  function automatic logic [P-1:0] span_of(input logic [P-1:0] a, input logic [P-1:0] b);
    logic [P-1:0] gap;
    gap     = (a >= b) ? (a - b) : (b - a);
    span_of = (gap == '0) ? POS_ONE : gap;
  endfunction

  // Stage enables: a stage advances when empty or when its successor advances.
  logic st1_valid, st2_valid, st3_valid;
  logic r1_valid, r2_valid, r3_valid;
  logic en_s1, en_s2, en_s3, en_r1, en_r2, en_r3;
  logic div_in_ready, div_out_valid;

  assign en_r3 = !r3_valid || follower.ready;
  assign en_r2 = !r2_valid || en_r3;
  assign en_r1 = !r1_valid || en_r2;
  assign en_s3 = !st3_valid || div_in_ready;
  assign en_s2 = !st2_valid || en_s3;
  assign en_s1 = !st1_valid || en_s2;
  assign leader.ready = en_s1;

  // Stage 1: leader offset and the leader span on its side of the center.
  logic signed [P:0] st1_d;
  logic [P-1:0]      st1_span;
  logic signed [P:0] d_next;

  assign d_next = signed'({1'b0, leader.leader_position}) - signed'({1'b0, leader_center});

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (en_s1) begin
      st1_valid <= leader.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      st1_d    <= d_next;
      st1_span <= d_next[P] ? span_of(leader_center, leader_low_limit)
                            : span_of(leader_high_limit, leader_center);
    end
  end

  // Stage 2: saturate the offset to one span, apply reversal, pick the follower span.
  logic [P-1:0] st2_mag;
  logic         st2_neg;
  logic [P-1:0] st2_span;
  logic [P-1:0] st2_fspan;
  logic [P:0]   d_negated;
  logic [P-1:0] d_mag;
  logic         n_neg;

  always_comb begin
    d_negated = -st1_d;
    d_mag     = st1_d[P] ? d_negated[P-1:0] : st1_d[P-1:0];
    n_neg     = (|st1_d) && (st1_d[P] ^ reverse_direction);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_valid <= 1'b0;
    end else if (en_s2) begin
      st2_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      st2_mag   <= (d_mag > st1_span) ? st1_span : d_mag;
      st2_neg   <= n_neg;
      st2_span  <= st1_span;
      st2_fspan <= n_neg ? span_of(follower_center, follower_low_limit)
                         : span_of(follower_high_limit, follower_center);
    end
  end

  // Stage 3: scale the offset magnitude by the follower span.
  logic [PROD_BITS-1:0] st3_prod;
  logic                 st3_neg;
  logic [P-1:0]         st3_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      st3_valid <= 1'b0;
    end else if (en_s3) begin
      st3_valid <= st2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s3) begin
      st3_prod <= PROD_BITS'(st2_mag) * PROD_BITS'(st2_fspan);
      st3_neg  <= st2_neg;
      st3_span <= st2_span;
    end
  end

  // Divide the scaled offset by the leader span.
  logic [P-1:0] div_quot;
  logic [P-1:0] div_rem;
  logic [P-1:0] div_divisor;
  logic         div_neg;

  spr_divider #(
    .POSITION_BITS (POSITION_BITS)
  ) u_divider (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (st3_valid),
    .in_ready    (div_in_ready),
    .in_dividend (st3_prod),
    .in_divisor  (st3_span),
    .in_neg      (st3_neg),
    .out_valid   (div_out_valid),
    .out_ready   (en_r1),
    .out_quot    (div_quot),
    .out_rem     (div_rem),
    .out_divisor (div_divisor),
    .out_neg     (div_neg)
  );

  // Center plus trim, the integer part of the target.
  logic signed [P+1:0] base;
  assign base = signed'({2'b00, follower_center}) + signed'({offset_trim[P], offset_trim});

  // Back stage 1: round the fraction half away from zero of the whole sum.
  // An exact half rounds the magnitude up when the offset and the total agree in sign.
  logic [P:0]          r1_mag;
  logic                r1_neg;
  logic signed [P+1:0] base_signed;
  logic signed [P+2:0] tie_sum;
  logic                tie_up;
  logic [P:0]          twice_rem;
  logic [P:0]          divisor_ext;
  logic                round_up;

  always_comb begin
    base_signed = div_neg ? -base : base;
    tie_sum     = signed'({base_signed[P+1], base_signed}) + signed'({3'b000, div_quot});
    tie_up      = !tie_sum[P+2];
    twice_rem   = {div_rem, 1'b0};
    divisor_ext = {1'b0, div_divisor};
    round_up    = (twice_rem > divisor_ext) || ((twice_rem == divisor_ext) && tie_up);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (en_r1) begin
      r1_valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_r1) begin
      r1_mag <= {1'b0, div_quot} + {{P{1'b0}}, round_up};
      r1_neg <= div_neg;
    end
  end

  // Back stage 2: add the signed rounded offset to the base.
  logic signed [P+2:0] r2_q;
  logic signed [P+2:0] mag_ext;
  logic signed [P+2:0] mag_signed;

  always_comb begin
    mag_ext    = signed'({2'b00, r1_mag});
    mag_signed = r1_neg ? -mag_ext : mag_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (en_r2) begin
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_r2) begin
      r2_q <= signed'({base[P+1], base}) + mag_signed;
    end
  end

  // Back stage 3: clamp into the follower limits; this is the output register.
  logic [P-1:0]        clamp_lo;
  logic [P-1:0]        clamp_hi;
  logic [P-1:0]        target_next;
  logic [P-1:0]        target;

  always_comb begin
    clamp_lo = (follower_low_limit < follower_high_limit) ? follower_low_limit
                                                          : follower_high_limit;
    clamp_hi = (follower_low_limit < follower_high_limit) ? follower_high_limit
                                                          : follower_low_limit;
    if (r2_q < signed'({3'b000, clamp_lo})) begin
      target_next = clamp_lo;
    end else if (r2_q > signed'({3'b000, clamp_hi})) begin
      target_next = clamp_hi;
    end else begin
      target_next = r2_q[P-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_valid <= 1'b0;
    end else if (en_r3) begin
      r3_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_r3) begin
      target <= target_next;
    end
  end

  assign follower.valid           = r3_valid;
  assign follower.mapped_position = target;

  // The divider remainder always ends below the divisor.
  `SPR_ASSERT_IMP(a_div_rem_below_divisor, div_out_valid, div_rem < div_divisor)
  // The rounded magnitude never exceeds POS_MAX by more than one.
  `SPR_ASSERT_IMP(a_round_mag_bound, r1_valid, !(r1_mag[P] && (|r1_mag[P-1:0])))
  // An accepted leader word always occupies the first stage on the next cycle.
  `SPR_ASSERT_NXT(a_accept_fills_stage1, leader.valid && leader.ready, st1_valid)

endmodule

### sv/spr_divider.sv
// Pipelined restoring divider for the servo position remap block.
// One quotient bit per stage; the dividend's upper half must be below the divisor.
module spr_divider #(
  parameter int POSITION_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2*POSITION_BITS-1:0] in_dividend,
  input  logic [POSITION_BITS-1:0]   in_divisor,
  input  logic                       in_neg,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [POSITION_BITS-1:0]   out_quot,
  output logic [POSITION_BITS-1:0]   out_rem,
  output logic [POSITION_BITS-1:0]   out_divisor,
  output logic                       out_neg
);

  localparam int P     = POSITION_BITS;
  localparam int STEPS = POSITION_BITS;

  logic [STEPS-1:0] vld;
  logic [STEPS:0]   en;
  logic [STEPS-1:0] neg;
  logic [P-1:0]     rem  [STEPS];
  logic [P-1:0]     low  [STEPS];
  logic [P-1:0]     divs [STEPS];

  assign en[STEPS] = out_ready;
  assign in_ready  = en[0];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [P-1:0] rem_in;
    logic [P-1:0] low_in;
    logic [P-1:0] div_in;
    logic         neg_in;
    logic         vld_in;
    logic [P:0]   trial;
    logic [P:0]   diff;
    logic         take;

    // Stage inputs come from the ports for the first step.
    if (k == 0) begin : g_first
      assign rem_in = in_dividend[2*P-1:P];
      assign low_in = in_dividend[P-1:0];
      assign div_in = in_divisor;
      assign neg_in = in_neg;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign low_in = low[k-1];
      assign div_in = divs[k-1];
      assign neg_in = neg[k-1];
      assign vld_in = vld[k-1];
    end

    // Shift in one dividend bit and subtract the divisor when it fits.
    assign trial = {rem_in, low_in[P-1]};
    assign diff  = trial - {1'b0, div_in};
    assign take  = (trial >= {1'b0, div_in});

    // A stage advances when empty or when the next stage advances.
    assign en[k] = !vld[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]  <= take ? diff[P-1:0] : trial[P-1:0];
        low[k]  <= {low_in[P-2:0], take};
        divs[k] <= div_in;
        neg[k]  <= neg_in;
      end
    end
  end

  assign out_valid   = vld[STEPS-1];
  assign out_quot    = low[STEPS-1];
  assign out_rem     = rem[STEPS-1];
  assign out_divisor = divs[STEPS-1];
  assign out_neg     = neg[STEPS-1];

endmodule
